// ----- src/pqs_pkg.sv -----
// ----------------------------------------------------------------------------
// pqs_pkg
// Shared types, widths and codes of the priority queue with a linear scan.
// ----------------------------------------------------------------------------
`default_nettype none

package pqs_pkg;

  localparam int unsigned DEPTH   = 1024;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned ENTRY_W = 2 * DATA_W;

  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_PEEK = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQ,
    CMD_DEQ,
    CMD_PEEK,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e                 kind;
    logic signed [DATA_W-1:0]  value;
    logic signed [DATA_W-1:0]  prio;
  } cmd_t;

endpackage

`default_nettype wire

// ----- src/pqs_req_if.sv -----
// ----------------------------------------------------------------------------
// pqs_req_if
// Request channel: one operation and its entry per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pqs_req_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         op;
  logic signed [pqs_pkg::DATA_W-1:0]  item_value;
  logic signed [pqs_pkg::DATA_W-1:0]  item_priority;

  modport source (output valid, output op, output item_value, output item_priority,
                  input ready);
  modport sink (input valid, input op, input item_value, input item_priority,
                output ready);
endinterface

`default_nettype wire

// ----- src/pqs_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pqs_rsp_if
// Response channel: one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface pqs_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic [pqs_pkg::IDX_W-1:0]          found_index;
  logic signed [pqs_pkg::DATA_W-1:0]  found_value;
  logic signed [pqs_pkg::DATA_W-1:0]  found_priority;
  logic [pqs_pkg::CNT_W-1:0]          occupancy;

  modport source (output valid, output status, output found_index, output found_value,
                  output found_priority, output occupancy, input ready);
  modport sink (input valid, input status, input found_index, input found_value,
                input found_priority, input occupancy, output ready);
endinterface

`default_nettype wire

// ----- src/pqs_front.sv -----
// ----------------------------------------------------------------------------
// pqs_front
// Accepts request beats, decodes the operation and holds the commands in a
// two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none

module pqs_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  pqs_req_if.sink            req_i,
  output pqs_pkg::cmd_t      cmd_o,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i
);

  pqs_pkg::cmd_t q_mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  pqs_pkg::cmd_t new_cmd;

  always_comb begin
    new_cmd.value = req_i.item_value;
    new_cmd.prio  = req_i.item_priority;
    case (req_i.op)
      pqs_pkg::OP_ENQ:  new_cmd.kind = pqs_pkg::CMD_ENQ;
      pqs_pkg::OP_DEQ:  new_cmd.kind = pqs_pkg::CMD_DEQ;
      pqs_pkg::OP_PEEK: new_cmd.kind = pqs_pkg::CMD_PEEK;
      default:          new_cmd.kind = pqs_pkg::CMD_NOP;
    endcase
  end

  assign req_i.ready = (cnt_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ cmd_pop_i;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/pqs_back.sv -----
// ----------------------------------------------------------------------------
// pqs_back
// Execution engine: holds the entry memory and the count, scans the held
// entries for the best one, shifts later entries down on a dequeue and
// registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module pqs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pqs_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  pqs_rsp_if.source          rsp_o
);

  localparam int unsigned IW = pqs_pkg::IDX_W;
  localparam int unsigned CW = pqs_pkg::CNT_W;
  localparam int unsigned DW = pqs_pkg::DATA_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [pqs_pkg::ENTRY_W-1:0] mem_q [pqs_pkg::DEPTH];
  logic [pqs_pkg::ENTRY_W-1:0] rd_data_q;

  logic [1:0]           state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        rd_ptr_q, rd_ptr_d;
  logic                 rv_q, rv_d;
  logic                 rlast_q, rlast_d;
  logic [IW-1:0]        rix_q, rix_d;
  logic                 deq_q, deq_d;
  logic [IW-1:0]        best_idx_q, best_idx_d;
  logic signed [DW-1:0] best_val_q, best_val_d;
  logic signed [DW-1:0] best_pri_q, best_pri_d;

  logic                 mem_we;
  logic [IW-1:0]        mem_wa;
  logic [pqs_pkg::ENTRY_W-1:0] mem_wd;
  logic [IW-1:0]        rd_addr;

  logic                 out_valid_q, out_valid_d;
  logic [1:0]           out_status_q;
  logic [IW-1:0]        out_idx_q;
  logic signed [DW-1:0] out_val_q;
  logic signed [DW-1:0] out_pri_q;
  logic [CW-1:0]        out_occ_q;

  logic                 ld;
  logic [1:0]           ld_status;
  logic [IW-1:0]        ld_idx;
  logic signed [DW-1:0] ld_val;
  logic signed [DW-1:0] ld_pri;
  logic [CW-1:0]        ld_occ;

  logic signed [DW-1:0] rd_val, rd_pri;
  logic                 take;
  logic [IW-1:0]        nb_idx;
  logic signed [DW-1:0] nb_val, nb_pri;
  logic                 out_free;
  logic                 issue;

  assign rd_val = rd_data_q[pqs_pkg::ENTRY_W-1:DW];
  assign rd_pri = rd_data_q[DW-1:0];
  assign take   = (rix_q == '0) || (rd_pri > best_pri_q) ||
                  ((rd_pri == best_pri_q) && (rd_val > best_val_q));
  assign nb_idx = take ? rix_q  : best_idx_q;
  assign nb_val = take ? rd_val : best_val_q;
  assign nb_pri = take ? rd_pri : best_pri_q;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign issue    = (rd_ptr_q < count_q);
  assign rd_addr  = rd_ptr_q[IW-1:0];

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    rd_ptr_d   = rd_ptr_q;
    rv_d       = 1'b0;
    rlast_d    = 1'b0;
    rix_d      = rix_q;
    deq_d      = deq_q;
    best_idx_d = best_idx_q;
    best_val_d = best_val_q;
    best_pri_d = best_pri_q;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;
    cmd_pop_o  = 1'b0;
    ld         = 1'b0;
    ld_status  = pqs_pkg::STATUS_OK;
    ld_idx     = '0;
    ld_val     = '0;
    ld_pri     = '0;
    ld_occ     = count_q;

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && out_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            pqs_pkg::CMD_ENQ: begin
              ld = 1'b1;
              if (count_q == CW'(pqs_pkg::DEPTH)) begin
                ld_status = pqs_pkg::STATUS_FULL;
              end else begin
                mem_we  = 1'b1;
                mem_wa  = count_q[IW-1:0];
                mem_wd  = {cmd_i.value, cmd_i.prio};
                count_d = count_q + CW'(1);
                ld_idx  = count_q[IW-1:0];
                ld_val  = cmd_i.value;
                ld_pri  = cmd_i.prio;
                ld_occ  = count_q + CW'(1);
              end
            end
            pqs_pkg::CMD_DEQ, pqs_pkg::CMD_PEEK: begin
              if (count_q == '0) begin
                ld        = 1'b1;
                ld_status = pqs_pkg::STATUS_EMPTY;
              end else begin
                state_d  = S_SCAN;
                rd_ptr_d = '0;
                deq_d    = (cmd_i.kind == pqs_pkg::CMD_DEQ);
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_q + CW'(1);
          rv_d     = 1'b1;
          rix_d    = rd_ptr_q[IW-1:0];
          rlast_d  = (rd_ptr_q == count_q - CW'(1));
        end
        if (rv_q) begin
          best_idx_d = nb_idx;
          best_val_d = nb_val;
          best_pri_d = nb_pri;
          if (rlast_q) begin
            if (deq_q) begin
              state_d  = S_SHIFT;
              rd_ptr_d = {1'b0, nb_idx} + CW'(1);
            end else begin
              state_d = S_IDLE;
              ld      = 1'b1;
              ld_idx  = nb_idx;
              ld_val  = nb_val;
              ld_pri  = nb_pri;
            end
          end
        end
      end
      S_SHIFT: begin
        if (issue) begin
          rd_ptr_d = rd_ptr_q + CW'(1);
          rv_d     = 1'b1;
          rix_d    = rd_ptr_q[IW-1:0];
        end
        if (rv_q) begin
          mem_we = 1'b1;
          mem_wa = rix_q - IW'(1);
          mem_wd = rd_data_q;
        end
        if (!issue && !rv_q) begin
          state_d = S_IDLE;
          count_d = count_q - CW'(1);
          ld      = 1'b1;
          ld_idx  = best_idx_q;
          ld_val  = best_val_q;
          ld_pri  = best_pri_q;
          ld_occ  = count_q - CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (ld) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    rix_q      <= rix_d;
    deq_q      <= deq_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    best_pri_q <= best_pri_d;
    if (ld) begin
      out_status_q <= ld_status;
      out_idx_q    <= ld_idx;
      out_val_q    <= ld_val;
      out_pri_q    <= ld_pri;
      out_occ_q    <= ld_occ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rd_ptr_q    <= '0;
      rv_q        <= 1'b0;
      rlast_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_ptr_q    <= rd_ptr_d;
      rv_q        <= rv_d;
      rlast_q     <= rlast_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.found_index    = out_idx_q;
  assign rsp_o.found_value    = out_val_q;
  assign rsp_o.found_priority = out_pri_q;
  assign rsp_o.occupancy      = out_occ_q;

endmodule

`default_nettype wire

// ----- src/priority_queue_scan.sv -----
// ----------------------------------------------------------------------------
// priority_queue_scan
// Priority queue of up to 1024 (value, priority) entries kept in arrival
// order, with enqueue, dequeue-highest and peek-highest operations.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one response beat. A peek scans the held
// entries through the single read port of the entry memory, one entry per
// cycle. A dequeue adds a shift of the entries behind the selected one, one
// per cycle. A two-entry command queue sits in front of the engine. The
// engine starts the next command only once the response register is free, so
// a result that waits holds back the commands behind it.
`default_nettype none

module priority_queue_scan (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pqs_req_if.sink    req_i,
  pqs_rsp_if.source  rsp_o
);

  pqs_pkg::cmd_t cmd;
  logic          cmd_valid;
  logic          cmd_pop;

  pqs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  pqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .rsp_o       (rsp_o)
  );

`ifndef SYNTH
  a_pop_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid)
    else $error("command popped from an empty queue");

  a_full_only_at_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == pqs_pkg::STATUS_FULL)
      |-> (rsp_o.occupancy == pqs_pkg::CNT_W'(pqs_pkg::DEPTH)))
    else $error("full status while the store has room");

  a_empty_zero_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.status == pqs_pkg::STATUS_EMPTY) |-> (rsp_o.occupancy == '0))
    else $error("empty status with nonzero occupancy");
`endif

endmodule

`default_nettype wire

// ----- verif/priority_queue_scan_chk.sv -----
// ----------------------------------------------------------------------------
// priority_queue_scan_chk
// Watches both channels of the priority queue, keeps its own copy of the
// held entries, works out the result of every accepted operation and checks
// each result beat field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_scan_chk (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pqs_req_if          req_i,
  pqs_rsp_if          rsp_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned full_rejects_o,
  output int unsigned empty_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [pqs_pkg::DATA_W-1:0] value;
    logic signed [pqs_pkg::DATA_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic [1:0]                        status;
    logic [pqs_pkg::IDX_W-1:0]         index;
    logic signed [pqs_pkg::DATA_W-1:0] value;
    logic signed [pqs_pkg::DATA_W-1:0] prio;
    logic [pqs_pkg::CNT_W-1:0]         occupancy;
  } result_t;

  entry_t  held_q[$];
  result_t expected_q[$];
  result_t want;
  result_t got;

  // Applies one operation to the held entries and returns what the queue
  // must report for it.
  function automatic result_t scan_outcome(input logic [1:0] op,
                                           input logic signed [pqs_pkg::DATA_W-1:0] value,
                                           input logic signed [pqs_pkg::DATA_W-1:0] prio);
    result_t r;
    int      best;
    r = '0;
    case (op)
      pqs_pkg::OP_ENQ: begin
        if (held_q.size() >= pqs_pkg::DEPTH) begin
          r.status = pqs_pkg::STATUS_FULL;
          full_rejects_o++;
        end else begin
          r.index = pqs_pkg::IDX_W'(held_q.size());
          r.value = value;
          r.prio  = prio;
          held_q.push_back('{value: value, prio: prio});
        end
      end
      pqs_pkg::OP_DEQ, pqs_pkg::OP_PEEK: begin
        if (held_q.size() == 0) begin
          r.status = pqs_pkg::STATUS_EMPTY;
          empty_hits_o++;
        end else begin
          best = 0;
          for (int i = 1; i < held_q.size(); i++) begin
            if (held_q[i].prio > held_q[best].prio ||
                (held_q[i].prio == held_q[best].prio &&
                 held_q[i].value > held_q[best].value)) begin
              best = i;
            end
          end
          r.index = pqs_pkg::IDX_W'(best);
          r.value = held_q[best].value;
          r.prio  = held_q[best].prio;
          if (op == pqs_pkg::OP_DEQ) begin
            held_q.delete(best);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = pqs_pkg::CNT_W'(held_q.size());
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [63:0] expected,
                             input logic signed [63:0] actual);
    if (actual !== expected) begin
      $display("%0t priority_queue_scan_chk: %s mismatch, expected %0d, actual %0d",
               $time, name, expected, actual);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q.delete();
      expected_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        got.status    = rsp_i.status;
        got.index     = rsp_i.found_index;
        got.value     = rsp_i.found_value;
        got.prio      = rsp_i.found_priority;
        got.occupancy = rsp_i.occupancy;
        if (expected_q.size() == 0) begin
          $display("%0t priority_queue_scan_chk: result beat with no operation outstanding,",
                   $time, " status %0d index %0d", got.status, got.index);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("found_index", 64'(want.index), 64'(got.index));
          check_field("found_value", 64'(want.value), 64'(got.value));
          check_field("found_priority", 64'(want.prio), 64'(got.prio));
          check_field("occupancy", 64'(want.occupancy), 64'(got.occupancy));
        end
      end
      if (req_i.valid && req_i.ready) begin
        expected_q.push_back(scan_outcome(req_i.op, req_i.item_value, req_i.item_priority));
      end
      pending_o <= expected_q.size();
    end
  end

endmodule

`default_nettype wire

// ----- verif/priority_queue_scan_tb.sv -----
// ----------------------------------------------------------------------------
// priority_queue_scan_tb
// Drives enqueue, dequeue, peek and unused operations into the priority queue
// with random idle cycles on both channels: a directed opening on the empty
// store, ties and extreme values, then a random phase at modest occupancy.
// The checker judges every result.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_queue_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned STALL_LIMIT  = 20000;
  localparam int unsigned RANDOM_ITEMS = 265;
  localparam int unsigned CALM_FIRST   = 120;
  localparam int unsigned CALM_LAST    = 170;
  localparam int unsigned HIGH_WATER   = 40;
  localparam int unsigned LOW_WATER    = 3;

  localparam logic [1:0] OP_NOP = pqs_pkg::CMD_NOP;

  localparam logic signed [pqs_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [pqs_pkg::DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          calm;
  int unsigned held_count;
  int unsigned beats_by_op[4];
  int unsigned stall_cycles;
  int unsigned errors;
  int unsigned pending;
  int unsigned full_rejects;
  int unsigned empty_hits;

  pqs_req_if req ();
  pqs_rsp_if rsp ();

  priority_queue_scan uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  priority_queue_scan_chk chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_i          (req),
    .rsp_i          (rsp),
    .errors_o       (errors),
    .pending_o      (pending),
    .full_rejects_o (full_rejects),
    .empty_hits_o   (empty_hits)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp.ready <= rst_ni && (calm || ($urandom_range(99) >= IDLE_PCT));
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t watchdog: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("priority_queue_scan_tb: FAIL");
      $finish;
    end
  end

  function automatic logic signed [pqs_pkg::DATA_W-1:0] pick_word();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 12) begin
      case ($urandom_range(3))
        0: return WORD_MIN;
        1: return WORD_MAX;
        2: return '0;
        default: return '1;
      endcase
    end else if (roll < 60) begin
      return $urandom_range(7) - 4;
    end
    return $urandom;
  endfunction

  task automatic send_op(input logic [1:0] op,
                         input logic signed [pqs_pkg::DATA_W-1:0] value,
                         input logic signed [pqs_pkg::DATA_W-1:0] prio);
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        req.valid <= 1'b0;
        @(posedge clk_i);
      end
    end
    req.valid         <= 1'b1;
    req.op            <= op;
    req.item_value    <= value;
    req.item_priority <= prio;
    @(posedge clk_i);
    while (!req.ready) begin
      @(posedge clk_i);
    end
    beats_by_op[op]++;
    if (op == pqs_pkg::OP_ENQ && held_count < pqs_pkg::DEPTH) begin
      held_count++;
    end else if (op == pqs_pkg::OP_DEQ && held_count > 0) begin
      held_count--;
    end
  endtask

  initial begin
    int unsigned roll;
    logic [1:0]  op;
    req.valid         <= 1'b0;
    req.op            <= pqs_pkg::OP_ENQ;
    req.item_value    <= '0;
    req.item_priority <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, lone most negative entry, ties and extreme values.
    send_op(pqs_pkg::OP_PEEK, pick_word(), pick_word());
    send_op(pqs_pkg::OP_DEQ, pick_word(), pick_word());
    send_op(OP_NOP, pick_word(), pick_word());
    send_op(pqs_pkg::OP_ENQ, WORD_MIN, WORD_MIN);
    send_op(pqs_pkg::OP_PEEK, pick_word(), pick_word());
    send_op(pqs_pkg::OP_DEQ, pick_word(), pick_word());
    send_op(pqs_pkg::OP_DEQ, pick_word(), pick_word());
    send_op(pqs_pkg::OP_ENQ, 5, 7);
    send_op(pqs_pkg::OP_ENQ, 9, 7);
    send_op(pqs_pkg::OP_ENQ, 9, 7);
    send_op(pqs_pkg::OP_ENQ, WORD_MAX, WORD_MIN);
    send_op(pqs_pkg::OP_ENQ, WORD_MIN, WORD_MAX);
    send_op(pqs_pkg::OP_ENQ, -1, WORD_MAX);
    send_op(pqs_pkg::OP_PEEK, pick_word(), pick_word());
    send_op(OP_NOP, WORD_MAX, WORD_MIN);
    repeat (4) send_op(pqs_pkg::OP_DEQ, pick_word(), pick_word());
    send_op(pqs_pkg::OP_ENQ, 0, 0);
    send_op(pqs_pkg::OP_ENQ, -1, -1);
    send_op(pqs_pkg::OP_PEEK, pick_word(), pick_word());
    repeat (3) send_op(pqs_pkg::OP_DEQ, pick_word(), pick_word());

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= CALM_FIRST) && (n < CALM_LAST);
      roll = $urandom_range(99);
      if (held_count < LOW_WATER) begin
        op = (roll < 70) ? pqs_pkg::OP_ENQ : (roll < 80) ? pqs_pkg::OP_DEQ :
             (roll < 92) ? pqs_pkg::OP_PEEK : OP_NOP;
      end else if (held_count > HIGH_WATER) begin
        op = (roll < 20) ? pqs_pkg::OP_ENQ : (roll < 75) ? pqs_pkg::OP_DEQ :
             (roll < 95) ? pqs_pkg::OP_PEEK : OP_NOP;
      end else begin
        op = (roll < 45) ? pqs_pkg::OP_ENQ : (roll < 75) ? pqs_pkg::OP_DEQ :
             (roll < 95) ? pqs_pkg::OP_PEEK : OP_NOP;
      end
      send_op(op, pick_word(), pick_word());
    end
    calm = 1'b0;
    req.valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) begin
      @(posedge clk_i);
    end
    repeat (20) @(posedge clk_i);

    $display("Sent %0d enqueue, %0d dequeue, %0d peek and %0d unused-op beats.",
             beats_by_op[pqs_pkg::OP_ENQ], beats_by_op[pqs_pkg::OP_DEQ],
             beats_by_op[pqs_pkg::OP_PEEK], beats_by_op[OP_NOP]);
    $display("Saw %0d full-store rejections and %0d empty-store results; %0d mismatches.",
             full_rejects, empty_hits, errors);
    if (errors == 0) begin
      $display("priority_queue_scan_tb: PASS");
    end else begin
      $display("priority_queue_scan_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
